// ===== design/alr_pkg.sv =====
// Shared types, widths and codes for the antialiased line rasterizer.
package alr_pkg;

  localparam int FRAC_W         = 16;
  localparam int SHADE_BITS_DEF = 3;
  localparam int HALF_UNIT      = 32768;

  localparam int IN_W      = 27;
  localparam int OFS_W     = 10;
  localparam int POS_W     = 28;
  localparam int DELTA_W   = 29;
  localparam int MAG_W     = 28;
  localparam int QUO_W     = 17;
  localparam int DIV_CNT_W = 5;
  localparam int GRAD_W    = 18;
  localparam int OFF_W     = 17;
  localparam int PROD_W    = GRAD_W + OFF_W;
  localparam int NEND_W    = 29;
  localparam int MINOR_W   = 32;
  localparam int PIX_W     = 12;
  localparam int IDX_W     = 13;
  localparam int WPROD_W   = 2 * FRAC_W;
  localparam int CFG_IDX_W = 1;

  localparam logic ACT_BEGIN   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DELTA,
    ST_ORDER,
    ST_DIV,
    ST_ROUND,
    ST_OFF,
    ST_PROD,
    ST_NEND,
    ST_WGT,
    ST_EMIT
  } alr_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DELTA,
    OP_ORDER,
    OP_DIV,
    OP_ROUND,
    OP_OFF,
    OP_PROD,
    OP_NEND,
    OP_WGT,
    OP_EMIT,
    OP_ADVANCE
  } alr_op_e;

  typedef struct packed {
    alr_op_e op;
    logic    ep;
  } alr_cmd_t;

  typedef struct packed {
    logic div_last;
    logic line_active;
  } alr_sts_t;

endpackage

// ===== design/alr_ctrl.sv =====
// Sequencer for the line rasterizer: handshakes, begin sequence, output valid.
module alr_ctrl import alr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     action_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  alr_sts_t sts_i,
  output alr_cmd_t cmd_o
);

  alr_state_e state_q, state_d;
  logic       ep_q, ep_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       load_out;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ep_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ep_q        <= ep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ep_d       = ep_q;
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.ep   = ep_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = !out_free;
        if (in_valid_i && out_free) begin
          if (action_i == ACT_BEGIN) begin
            cmd_o.op = OP_LOAD;
            ep_d     = 1'b0;
            state_d  = ST_DELTA;
          end else if (sts_i.line_active) begin
            cmd_o.op = OP_ADVANCE;
            load_out = 1'b1;
          end
        end
      end
      ST_DELTA: begin
        cmd_o.op = OP_DELTA;
        state_d  = ST_ORDER;
      end
      ST_ORDER: begin
        cmd_o.op = OP_ORDER;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (sts_i.div_last) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.op = OP_ROUND;
        state_d  = ST_OFF;
      end
      ST_OFF: begin
        cmd_o.op = OP_OFF;
        state_d  = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.op = OP_PROD;
        state_d  = ST_NEND;
      end
      ST_NEND: begin
        cmd_o.op = OP_NEND;
        state_d  = ST_WGT;
      end
      ST_WGT: begin
        cmd_o.op = OP_WGT;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.op = OP_EMIT;
          load_out = 1'b1;
          if (ep_q) begin
            state_d = ST_IDLE;
          end else begin
            ep_d    = 1'b1;
            state_d = ST_OFF;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

endmodule

// ===== design/alr_dp.sv =====
// Datapath: endpoint setup, gradient divider, endpoint weights, interior stepping.
module alr_dp import alr_pkg::*; #(
  parameter int SHADE_BITS = SHADE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  alr_cmd_t                     cmd_i,
  output alr_sts_t                     sts_o,
  input  logic signed [IN_W-1:0]       start_x_i,
  input  logic signed [IN_W-1:0]       start_y_i,
  input  logic signed [IN_W-1:0]       end_x_i,
  input  logic signed [IN_W-1:0]       end_y_i,
  input  logic                         cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [OFS_W-1:0]             cfg_data_i,
  output logic signed [PIX_W-1:0]      pixel_x_o,
  output logic signed [PIX_W-1:0]      pixel_y_o,
  output logic [SHADE_BITS-1:0]        shade_main_o,
  output logic [SHADE_BITS-1:0]        shade_side_o,
  output logic                         side_along_y_o,
  output logic                         last_of_line_o
);

  logic [OFS_W-1:0]          x_off_q, y_off_q;
  logic signed [POS_W-1:0]   x1_q, y1_q, x2_q, y2_q;
  logic [MAG_W-1:0]          adx_q, ady_q;
  logic                      dx_neg_q, dy_neg_q;
  logic signed [POS_W-1:0]   a1_q, b1_q, a2_q, b2_q;
  logic                      xmaj_q;
  logic [MAG_W-1:0]          den_q;
  logic                      den_zero_q, neg_q;
  logic [MAG_W:0]            rem_q;
  logic [QUO_W-1:0]          quo_q;
  logic [DIV_CNT_W-1:0]      cnt_q;
  logic signed [GRAD_W-1:0]  grad_q;
  logic signed [OFF_W-1:0]   off_q;
  logic [FRAC_W-1:0]         gap_q;
  logic signed [IDX_W-1:0]   i1_q, i2_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [NEND_W-1:0]  nend_q;
  logic [SHADE_BITS-1:0]     wmain_q, wside_q;
  logic [MINOR_W-1:0]        minor_q;
  logic signed [IDX_W-1:0]   maj_cur_q, maj_last_q;
  logic                      active_q;
  logic signed [PIX_W-1:0]   px_q, py_q;
  logic [SHADE_BITS-1:0]     sm_q, ss_q;
  logic                      side_q, last_q;

  // setup
  logic signed [DELTA_W-1:0] dx, dy;
  logic [DELTA_W-1:0]        adx_full, ady_full;
  logic                      xmaj_new, swap, minor_neg;
  logic [MAG_W-1:0]          num_mag, den_new;
  logic signed [POS_W-1:0]   maj1, maj2, min1, min2;

  // divider
  logic                      div_ge;
  logic [MAG_W:0]            div_sub;
  logic                      div_last;
  logic                      round_up;
  logic [QUO_W-1:0]          quo_rnd;
  logic signed [GRAD_W-1:0]  grad_new;

  // endpoint
  logic signed [POS_W-1:0]   a_sel, b_sel;
  logic [FRAC_W-1:0]         h_low;
  logic signed [DELTA_W-1:0] h_full;
  logic signed [PROD_W-1:0]  prod_new, prod_sh;
  logic [FRAC_W-1:0]         nfrac, nfrac_inv;
  logic [WPROD_W-1:0]        wm_full, ws_full;
  logic signed [IDX_W:0]     span;
  logic                      active_new;
  logic [MINOR_W-1:0]        grad_ext, nend_ext;

  // emit
  logic                      adv_last;
  logic signed [PIX_W-1:0]   e_major, e_minor;
  logic [SHADE_BITS-1:0]     e_sm, e_ss;
  logic                      e_last;
  logic                      load_out;

  assign dx = $signed({x2_q[POS_W-1], x2_q}) - $signed({x1_q[POS_W-1], x1_q});
  assign dy = $signed({y2_q[POS_W-1], y2_q}) - $signed({y1_q[POS_W-1], y1_q});
  assign adx_full = dx[DELTA_W-1] ? -dx : dx;
  assign ady_full = dy[DELTA_W-1] ? -dy : dy;

  assign xmaj_new  = adx_q > ady_q;
  assign swap      = xmaj_new ? dx_neg_q : dy_neg_q;
  assign minor_neg = xmaj_new ? dy_neg_q : dx_neg_q;
  assign num_mag   = xmaj_new ? ady_q : adx_q;
  assign den_new   = xmaj_new ? adx_q : ady_q;
  assign maj1      = xmaj_new ? x1_q : y1_q;
  assign maj2      = xmaj_new ? x2_q : y2_q;
  assign min1      = xmaj_new ? y1_q : x1_q;
  assign min2      = xmaj_new ? y2_q : x2_q;

  assign div_ge   = rem_q >= {1'b0, den_q};
  assign div_sub  = div_ge ? (rem_q - {1'b0, den_q}) : rem_q;
  assign div_last = cnt_q == DIV_CNT_W'(QUO_W - 1);
  assign round_up = {rem_q, 1'b0} >= {2'b00, den_q};
  assign quo_rnd  = quo_q + QUO_W'(round_up);
  assign grad_new = den_zero_q ? '0 :
                    (neg_q ? -$signed({1'b0, quo_rnd}) : $signed({1'b0, quo_rnd}));

  assign a_sel  = cmd_i.ep ? a2_q : a1_q;
  assign b_sel  = cmd_i.ep ? b2_q : b1_q;
  assign h_low  = {~a_sel[FRAC_W-1], a_sel[FRAC_W-2:0]};
  assign h_full = $signed({a_sel[POS_W-1], a_sel}) + $signed(DELTA_W'(HALF_UNIT));
  assign prod_new = grad_q * off_q;
  assign prod_sh  = prod_q >>> FRAC_W;
  assign nfrac    = nend_q[FRAC_W-1:0];
  assign nfrac_inv = ~nfrac;
  assign wm_full  = nfrac_inv * gap_q;
  assign ws_full  = nfrac * gap_q;

  assign span       = $signed({i2_q[IDX_W-1], i2_q}) - $signed({i1_q[IDX_W-1], i1_q});
  assign active_new = span >= $signed((IDX_W + 1)'(2));
  assign grad_ext   = {{(MINOR_W - GRAD_W){grad_q[GRAD_W-1]}}, grad_q};
  assign nend_ext   = {{(MINOR_W - NEND_W){nend_q[NEND_W-1]}}, nend_q};

  assign adv_last = maj_cur_q >= maj_last_q;

  always_comb begin
    if (cmd_i.op == OP_ADVANCE) begin
      e_major = maj_cur_q[PIX_W-1:0];
      e_minor = minor_q[FRAC_W +: PIX_W];
      e_sm    = ~minor_q[FRAC_W-1 -: SHADE_BITS];
      e_ss    = minor_q[FRAC_W-1 -: SHADE_BITS];
      e_last  = adv_last;
    end else begin
      e_major = cmd_i.ep ? i2_q[PIX_W-1:0] : i1_q[PIX_W-1:0];
      e_minor = nend_q[FRAC_W +: PIX_W];
      e_sm    = wmain_q;
      e_ss    = wside_q;
      e_last  = cmd_i.ep && !active_new;
    end
  end

  assign load_out = (cmd_i.op == OP_EMIT) || (cmd_i.op == OP_ADVANCE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q    <= '0;
      y_off_q    <= '0;
      xmaj_q     <= 1'b0;
      cnt_q      <= '0;
      grad_q     <= '0;
      minor_q    <= '0;
      maj_cur_q  <= '0;
      maj_last_q <= '0;
      active_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_X_OFFSET: x_off_q <= cfg_data_i;
          CFG_Y_OFFSET: y_off_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_ORDER: begin
          xmaj_q <= xmaj_new;
          cnt_q  <= '0;
        end
        OP_DIV: begin
          cnt_q <= cnt_q + DIV_CNT_W'(1);
        end
        OP_ROUND: begin
          grad_q <= grad_new;
        end
        OP_EMIT: begin
          if (cmd_i.ep) begin
            active_q   <= active_new;
            maj_cur_q  <= i1_q + IDX_W'(1);
            maj_last_q <= i2_q - IDX_W'(1);
          end else begin
            minor_q <= nend_ext + grad_ext;
          end
        end
        OP_ADVANCE: begin
          minor_q <= minor_q + grad_ext;
          if (adv_last) begin
            active_q <= 1'b0;
          end else begin
            maj_cur_q <= maj_cur_q + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x1_q <= $signed({start_x_i[IN_W-1], start_x_i}) + $signed({2'b00, x_off_q, 16'h0000});
        y1_q <= $signed({start_y_i[IN_W-1], start_y_i}) + $signed({2'b00, y_off_q, 16'h0000});
        x2_q <= $signed({end_x_i[IN_W-1], end_x_i}) + $signed({2'b00, x_off_q, 16'h0000});
        y2_q <= $signed({end_y_i[IN_W-1], end_y_i}) + $signed({2'b00, y_off_q, 16'h0000});
      end
      OP_DELTA: begin
        adx_q    <= adx_full[MAG_W-1:0];
        ady_q    <= ady_full[MAG_W-1:0];
        dx_neg_q <= dx[DELTA_W-1];
        dy_neg_q <= dy[DELTA_W-1];
      end
      OP_ORDER: begin
        a1_q       <= swap ? maj2 : maj1;
        a2_q       <= swap ? maj1 : maj2;
        b1_q       <= swap ? min2 : min1;
        b2_q       <= swap ? min1 : min2;
        den_q      <= den_new;
        den_zero_q <= den_new == '0;
        neg_q      <= (num_mag != '0) && (minor_neg ^ swap);
        rem_q      <= {1'b0, num_mag};
        quo_q      <= '0;
      end
      OP_DIV: begin
        quo_q <= {quo_q[QUO_W-2:0], div_ge};
        rem_q <= div_last ? div_sub : {div_sub[MAG_W-1:0], 1'b0};
      end
      OP_OFF: begin
        off_q <= $signed(OFF_W'(HALF_UNIT)) - $signed({1'b0, h_low});
        gap_q <= ~h_low;
        if (cmd_i.ep) begin
          i2_q <= h_full[DELTA_W-1:FRAC_W];
        end else begin
          i1_q <= h_full[DELTA_W-1:FRAC_W];
        end
      end
      OP_PROD: begin
        prod_q <= prod_new;
      end
      OP_NEND: begin
        nend_q <= $signed({b_sel[POS_W-1], b_sel}) + prod_sh[NEND_W-1:0];
      end
      OP_WGT: begin
        wmain_q <= wm_full[WPROD_W-1 -: SHADE_BITS];
        wside_q <= ws_full[WPROD_W-1 -: SHADE_BITS];
      end
      default: ;
    endcase
    if (load_out) begin
      px_q   <= xmaj_q ? e_major : e_minor;
      py_q   <= xmaj_q ? e_minor : e_major;
      sm_q   <= e_sm;
      ss_q   <= e_ss;
      side_q <= xmaj_q;
      last_q <= e_last;
    end
  end

  assign sts_o.div_last    = div_last;
  assign sts_o.line_active = active_q;

  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign shade_main_o   = sm_q;
  assign shade_side_o   = ss_q;
  assign side_along_y_o = side_q;
  assign last_of_line_o = last_q;

endmodule

// ===== design/antialiased_line_rasterizer.sv =====
// Top level of the antialiased line rasterizer: sequencer plus datapath.
//
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------------------
//  in      | in_valid_i / in_stall_o   | action_i, start_x_i, start_y_i, end_x_i, end_y_i
//  out     | out_valid_o / out_stall_i | pixel_x_o, pixel_y_o, shade_main_o,
//          |                           | shade_side_o, side_along_y_o, last_of_line_o
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Advance: one pair per cycle while out is not stalled and no begin is being set up.
// Begin: the first pair shows after the delta, order, restoring divider and round steps
// for the gradient and the shared offset/product/minor-end/weight stages for the first
// endpoint; those stages run again for the second pair, and input stalls until both are out.
// Reset clears offsets, gradient, line state and the output valid.
// A stalled output holds its pair; input is stalled until the output register is free.
module antialiased_line_rasterizer import alr_pkg::*; #(
  parameter int SHADE_BITS = SHADE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    action_i,
  input  logic signed [IN_W-1:0]  start_x_i,
  input  logic signed [IN_W-1:0]  start_y_i,
  input  logic signed [IN_W-1:0]  end_x_i,
  input  logic signed [IN_W-1:0]  end_y_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [PIX_W-1:0] pixel_x_o,
  output logic signed [PIX_W-1:0] pixel_y_o,
  output logic [SHADE_BITS-1:0]   shade_main_o,
  output logic [SHADE_BITS-1:0]   shade_side_o,
  output logic                    side_along_y_o,
  output logic                    last_of_line_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [OFS_W-1:0]        cfg_data_i
);

  alr_cmd_t cmd;
  alr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  alr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  alr_dp #(
    .SHADE_BITS (SHADE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .shade_main_o   (shade_main_o),
    .shade_side_o   (shade_side_o),
    .side_along_y_o (side_along_y_o),
    .last_of_line_o (last_of_line_o)
  );

endmodule

// ===== design/alr_checker.sv =====
// Port-level checks for the antialiased line rasterizer, bound to the top level.
module alr_checker import alr_pkg::*; #(
  parameter int SHADE_BITS = SHADE_BITS_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    action_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [PIX_W-1:0] pixel_x_o,
  input logic signed [PIX_W-1:0] pixel_y_o,
  input logic [SHADE_BITS-1:0]   shade_main_o,
  input logic [SHADE_BITS-1:0]   shade_side_o,
  input logic                    side_along_y_o,
  input logic                    last_of_line_o
);

  logic begin_txn;
  assign begin_txn = in_valid_i && !in_stall_o && (action_i == ACT_BEGIN);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_x_o) && $stable(pixel_y_o) &&
      $stable(shade_main_o) && $stable(shade_side_o) &&
      $stable(side_along_y_o) && $stable(last_of_line_o))
    else $error("stalled output payload changed");

  a_begin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    begin_txn |=> in_stall_o)
    else $error("input taken while a begin is being set up");

  a_begin_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    begin_txn |=> !out_valid_o)
    else $error("output shown right after begin transaction");

endmodule

bind antialiased_line_rasterizer alr_checker #(.SHADE_BITS(SHADE_BITS)) u_alr_checker (.*);

// ===== dv/antialiased_line_rasterizer_tb.sv =====
// Self-checking testbench for the antialiased line rasterizer: directed table plus random lines.
module antialiased_line_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alr_pkg::*;

  localparam int     SHADE_W       = SHADE_BITS_DEF;
  localparam int     SHADE_SH      = FRAC_W - SHADE_W;
  localparam longint ONE           = 64'sd65536;
  localparam longint COORD_MAX     = 64'sd67108863;
  localparam longint COORD_MIN     = -64'sd67108864;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     PHASE_ITEMS   = 190;
  localparam int     N_PHASES      = 6;
  localparam int     HOLD_PHASE    = 1;
  localparam int     PAUSE_PHASE   = 2;
  localparam int     PH_X_OFS [N_PHASES] = '{1023, 0, 1023, -1, -1, 0};
  localparam int     PH_Y_OFS [N_PHASES] = '{1023, 1023, 0, -1, -1, 0};
  localparam bit     PH_IDLE  [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

  typedef struct packed {
    logic                   action;
    logic signed [IN_W-1:0] sx;
    logic signed [IN_W-1:0] sy;
    logic signed [IN_W-1:0] ex;
    logic signed [IN_W-1:0] ey;
  } seg_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] px;
    logic signed [PIX_W-1:0] py;
    logic [SHADE_W-1:0]      sm;
    logic [SHADE_W-1:0]      ss;
    logic                    along_y;
    logic                    last;
  } pair_t;

  typedef struct {
    seg_item_t it;
    int        nfix;
    pair_t     f0;
    pair_t     f1;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    action_i;
  logic signed [IN_W-1:0]  start_x_i;
  logic signed [IN_W-1:0]  start_y_i;
  logic signed [IN_W-1:0]  end_x_i;
  logic signed [IN_W-1:0]  end_y_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [PIX_W-1:0] pixel_x_o;
  logic signed [PIX_W-1:0] pixel_y_o;
  logic [SHADE_W-1:0]      shade_main_o;
  logic [SHADE_W-1:0]      shade_side_o;
  logic                    side_along_y_o;
  logic                    last_of_line_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [OFS_W-1:0]        cfg_data_i;

  antialiased_line_rasterizer #(.SHADE_BITS(SHADE_W)) dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [OFS_W-1:0] x_off     = '0;
  logic [OFS_W-1:0] y_off     = '0;
  longint           grad      = 0;
  longint           minor_pos = 0;
  longint           major_cur = 0;
  longint           major_end = 0;
  bit               x_major   = 1'b0;
  bit               line_on   = 1'b0;

  pair_t    pending_pairs[$];
  dir_row_t dir_tab[$];
  int       mismatches = 0;
  int       pairs_seen = 0;
  bit       idle_on    = 1'b1;
  int       hold_len   = 0;

  function automatic longint fx_frac(longint v);
    return v & (ONE - 1);
  endfunction

  function automatic longint fx_invfrac(longint v);
    return (ONE - 1) - fx_frac(v);
  endfunction

  function automatic longint fx_trunc(longint v);
    return v - fx_frac(v);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FRAC_W;
  endfunction

  function automatic longint wrap32(longint v);
    logic signed [31:0] w;
    w = v[31:0];
    return longint'(w);
  endfunction

  // gradient, rounded half away from zero
  function automatic longint grad_div(longint num, longint den);
    longint n, d, q;
    if (den == 0) return 0;
    n = (num < 0 ? -num : num) * ONE;
    d = den < 0 ? -den : den;
    q = (2 * n + d) / (2 * d);
    if (q > 2147483647) q = 2147483647;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic pair_t pair_of(int px, int py, int sm, int ss, bit ay, bit last);
    pair_t p;
    p.px      = PIX_W'(px);
    p.py      = PIX_W'(py);
    p.sm      = SHADE_W'(sm);
    p.ss      = SHADE_W'(ss);
    p.along_y = ay;
    p.last    = last;
    return p;
  endfunction

  function automatic pair_t make_pair(longint major, longint minor, longint wmain,
                                      longint wside, bit last);
    return pair_of(int'(x_major ? major : minor), int'(x_major ? minor : major),
                   int'(wmain >>> SHADE_SH), int'(wside >>> SHADE_SH), x_major, last);
  endfunction

  function automatic int rasterize(input seg_item_t it, output pair_t r0, output pair_t r1);
    longint x1, y1, x2, y2, dx, dy, a1, b1, a2, b2, t, g, mend, nend, gap, i1, i2;
    bit     last;
    r0 = '0;
    r1 = '0;
    if (it.action == ACT_ADVANCE) begin
      if (!line_on) return 0;
      last = major_cur >= major_end;
      r0 = make_pair(major_cur, minor_pos >>> FRAC_W, fx_invfrac(minor_pos),
                     fx_frac(minor_pos), last);
      minor_pos = wrap32(minor_pos + grad);
      if (last) line_on = 1'b0;
      else major_cur++;
      return 1;
    end
    x1 = longint'(signed'(it.sx)) + longint'(x_off) * ONE;
    y1 = longint'(signed'(it.sy)) + longint'(y_off) * ONE;
    x2 = longint'(signed'(it.ex)) + longint'(x_off) * ONE;
    y2 = longint'(signed'(it.ey)) + longint'(y_off) * ONE;
    dx = x2 - x1;
    dy = y2 - y1;
    x_major = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy);
    if (x_major) begin
      a1 = x1; b1 = y1; a2 = x2; b2 = y2;
    end else begin
      a1 = y1; b1 = x1; a2 = y2; b2 = x2;
    end
    if (a1 > a2) begin
      t = a1; a1 = a2; a2 = t;
      t = b1; b1 = b2; b2 = t;
    end
    g = grad_div(b2 - b1, a2 - a1);
    grad = wrap32(g);

    mend = fx_trunc(a1 + HALF_UNIT);
    nend = b1 + fx_mul(g, mend - a1);
    gap  = fx_invfrac(a1 + HALF_UNIT);
    i1   = mend >>> FRAC_W;
    r0 = make_pair(i1, nend >>> FRAC_W, fx_mul(fx_invfrac(nend), gap),
                   fx_mul(fx_frac(nend), gap), 1'b0);
    minor_pos = wrap32(nend + g);

    // second endpoint gap is deliberately taken at major - 1/2
    mend = fx_trunc(a2 + HALF_UNIT);
    nend = b2 + fx_mul(g, mend - a2);
    gap  = fx_invfrac(a2 - HALF_UNIT);
    i2   = mend >>> FRAC_W;
    line_on = (i2 - i1) >= 2;
    r1 = make_pair(i2, nend >>> FRAC_W, fx_mul(fx_invfrac(nend), gap),
                   fx_mul(fx_frac(nend), gap), !line_on);
    major_cur = i1 + 1;
    major_end = i2 - 1;
    return 2;
  endfunction

  function automatic longint rand_coord();
    return longint'(signed'(IN_W'($urandom)));
  endfunction

  function automatic logic signed [IN_W-1:0] fit_coord(longint v, bit snap);
    logic signed [IN_W-1:0] c;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    c = IN_W'(v);
    if (snap) c[FRAC_W-1:0] = $urandom_range(1, 0) ? 16'h8000 : 16'h0000;
    return c;
  endfunction

  function automatic seg_item_t random_begin();
    seg_item_t it;
    longint    sx, sy, ex, ey, dmaj, dmin;
    int        kind;
    bit        snap;
    kind = $urandom_range(15, 0);
    snap = kind >= 12;
    sx   = rand_coord();
    sy   = rand_coord();
    dmaj = longint'($urandom_range(20 * 65536, 0));
    dmin = longint'($urandom_range(int'(dmaj), 0));
    if (kind == 2) dmin = dmaj;
    if ($urandom_range(1, 0)) dmaj = -dmaj;
    if ($urandom_range(1, 0)) dmin = -dmin;
    if ($urandom_range(1, 0)) begin
      ex = sx + dmaj; ey = sy + dmin;
    end else begin
      ex = sx + dmin; ey = sy + dmaj;
    end
    if (kind == 1) begin
      ex = sx; ey = sy;
    end
    if (kind == 0) begin
      ex = rand_coord(); ey = rand_coord();
    end
    it.action = ACT_BEGIN;
    it.sx = fit_coord(sx, snap);
    it.sy = fit_coord(sy, snap);
    it.ex = fit_coord(ex, snap);
    it.ey = fit_coord(ey, snap);
    return it;
  endfunction

  function automatic seg_item_t random_advance();
    seg_item_t it;
    it.action = ACT_ADVANCE;
    it.sx = IN_W'($urandom);
    it.sy = IN_W'($urandom);
    it.ex = IN_W'($urandom);
    it.ey = IN_W'($urandom);
    return it;
  endfunction

  task automatic add_row(input logic act, input longint sx, input longint sy,
                         input longint ex, input longint ey, input int nfix,
                         input pair_t f0, input pair_t f1);
    dir_row_t r;
    r.it.action = act;
    r.it.sx = IN_W'(sx);
    r.it.sy = IN_W'(sy);
    r.it.ex = IN_W'(ex);
    r.it.ey = IN_W'(ey);
    r.nfix = nfix;
    r.f0 = f0;
    r.f1 = f1;
    dir_tab.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("[%0t] pair %0d: %s", $time, pairs_seen, msg);
  endtask

  // nfix >= 0 replaces the predicted pairs by the ones typed in the table
  task automatic drive_item(input seg_item_t it, input int nfix, input pair_t f0,
                            input pair_t f1);
    pair_t r0, r1;
    int    n, gap;
    gap = idle_on ? $urandom_range(7, 0) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i  = it.action;
    start_x_i = it.sx;
    start_y_i = it.sy;
    end_x_i   = it.ex;
    end_y_i   = it.ey;
    do @(posedge clk_i); while (in_stall_o);
    n = rasterize(it, r0, r1);
    if (nfix >= 0) begin
      n = nfix; r0 = f0; r1 = f1;
    end
    if (n > 0) pending_pairs.push_back(r0);
    if (n > 1) pending_pairs.push_back(r1);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_offsets(input logic [OFS_W-1:0] xo, input logic [OFS_W-1:0] yo);
    settle();
    cfg_valid_i = 1'b1;
    cfg_index_i = CFG_X_OFFSET;
    cfg_data_i  = xo;
    do @(posedge clk_i); while (!cfg_ready_o);
    x_off = xo;
    @(negedge clk_i);
    cfg_index_i = CFG_Y_OFFSET;
    cfg_data_i  = yo;
    do @(posedge clk_i); while (!cfg_ready_o);
    y_off = yo;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // well-formed lines with random content, some abandoned early, some trailing strays
  task automatic run_lines(input int goal);
    int sent, budget, mode, k;
    sent = 0;
    while (sent < goal) begin
      drive_item(random_begin(), -1, '0, '0);
      sent++;
      mode = $urandom_range(9, 0);
      budget = (mode == 0) ? $urandom_range(12, 0) : 64;
      while (line_on && sent < goal && budget > 0) begin
        drive_item(random_advance(), -1, '0, '0);
        sent++;
        budget--;
      end
      if (mode == 1 && !line_on) begin
        for (k = 0; k < $urandom_range(3, 1); k++) drive_item(random_advance(), -1, '0, '0);
      end
    end
  endtask

  initial begin : receive_pairs
    pair_t got, want;
    int    n;
    out_stall_i = 1'b0;
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end else begin
        n = idle_on ? $urandom_range(7, 0) : 0;
      end
      if (n > 0) begin
        out_stall_i = 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      pairs_seen++;
      got = pair_of(int'(pixel_x_o), int'(pixel_y_o), int'(shade_main_o),
                    int'(shade_side_o), side_along_y_o, last_of_line_o);
      if (pending_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected pair at (%0d,%0d)", got.px, got.py));
      end else begin
        want = pending_pairs.pop_front();
        if (got.px !== want.px)
          report_mismatch($sformatf("pixel_x %0d, expected %0d", got.px, want.px));
        if (got.py !== want.py)
          report_mismatch($sformatf("pixel_y %0d, expected %0d", got.py, want.py));
        if (got.sm !== want.sm)
          report_mismatch($sformatf("shade_main %0d, expected %0d", got.sm, want.sm));
        if (got.ss !== want.ss)
          report_mismatch($sformatf("shade_side %0d, expected %0d", got.ss, want.ss));
        if (got.along_y !== want.along_y)
          report_mismatch($sformatf("side_along_y %0b, expected %0b", got.along_y,
                                    want.along_y));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_of_line %0b, expected %0b", got.last, want.last));
      end
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [OFS_W-1:0] xo, yo;
    int               p;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = ACT_BEGIN;
    start_x_i   = '0;
    start_y_i   = '0;
    end_x_i     = '0;
    end_y_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_X_OFFSET;
    cfg_data_i  = '0;

    // no line yet, zero-length line, short integer x line walked to its end
    add_row(ACT_ADVANCE, 0, 0, 0, 0, 0, '0, '0);
    add_row(ACT_BEGIN, 0, 0, 0, 0, 2, pair_of(0, 0, 3, 0, 1'b0, 1'b0),
            pair_of(0, 0, 3, 0, 1'b0, 1'b1));
    add_row(ACT_BEGIN, 0, 0, 3 * ONE, 0, 2, pair_of(0, 0, 3, 0, 1'b1, 1'b0),
            pair_of(3, 0, 3, 0, 1'b1, 1'b0));
    add_row(ACT_ADVANCE, 0, 0, 0, 0, 1, pair_of(1, 0, 7, 0, 1'b1, 1'b0), '0);
    add_row(ACT_ADVANCE, 0, 0, 0, 0, 1, pair_of(2, 0, 7, 0, 1'b1, 1'b1), '0);
    add_row(ACT_ADVANCE, 0, 0, 0, 0, 0, '0, '0);
    // full-range diagonal, then abandoned by a swapped x-major line
    add_row(ACT_BEGIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, -1, '0, '0);
    add_row(ACT_ADVANCE, 0, 0, 0, 0, -1, '0, '0);
    add_row(ACT_ADVANCE, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, -1, '0, '0);
    add_row(ACT_BEGIN, COORD_MAX, 0, COORD_MIN, 1234567, -1, '0, '0);
    add_row(ACT_ADVANCE, 0, 0, 0, 0, -1, '0, '0);
    // half-pixel start, y major
    add_row(ACT_BEGIN, 32768, 32768, 98304, 311296, -1, '0, '0);
    add_row(ACT_ADVANCE, 0, 0, 0, 0, -1, '0, '0);
    add_row(ACT_ADVANCE, 0, 0, 0, 0, -1, '0, '0);
    add_row(ACT_ADVANCE, 0, 0, 0, 0, -1, '0, '0);
    add_row(ACT_ADVANCE, 0, 0, 0, 0, -1, '0, '0);
    // negative coordinates, falling gradient
    add_row(ACT_BEGIN, -216269, 131072, 308019, -72090, -1, '0, '0);
    add_row(ACT_ADVANCE, 0, 0, 0, 0, -1, '0, '0);
    add_row(ACT_ADVANCE, 0, 0, 0, 0, -1, '0, '0);
    // zero-length line at the top corner
    add_row(ACT_BEGIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, -1, '0, '0);
    add_row(ACT_ADVANCE, 0, 0, 0, 0, -1, '0, '0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_offsets('0, '0);
    foreach (dir_tab[i]) drive_item(dir_tab[i].it, dir_tab[i].nfix, dir_tab[i].f0,
                                    dir_tab[i].f1);

    for (p = 0; p < N_PHASES; p++) begin
      xo = PH_X_OFS[p] < 0 ? OFS_W'($urandom) : OFS_W'(PH_X_OFS[p]);
      yo = PH_Y_OFS[p] < 0 ? OFS_W'($urandom) : OFS_W'(PH_Y_OFS[p]);
      set_offsets(xo, yo);
      idle_on = PH_IDLE[p];
      if (p == HOLD_PHASE) hold_len = HOLD_CYCLES;
      if (p == PAUSE_PHASE) begin
        run_lines(PHASE_ITEMS / 2);
        settle();
        run_lines(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_lines(PHASE_ITEMS);
      end
    end

    settle();
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
